>>> hw/rtl/pqsm_pkg.sv
// Package for the pitch quad servo mixer: register indexes, fixed-point constants,
// divider geometry and the sideband type carried alongside the dividers.
// No dependencies.
`default_nettype none

package pqsm_pkg;

  typedef enum logic [2:0] {
    REG_OFFSET0  = 3'd0,
    REG_OFFSET1  = 3'd1,
    REG_OFFSET2  = 3'd2,
    REG_OFFSET3  = 3'd3,
    REG_DLIMIT   = 3'd4,
    REG_CAL_MODE = 3'd5
  } cfg_reg_e;

  // Mixing gains
  localparam logic signed [31:0] K1_Q16 = 32'sd6914539;
  localparam logic signed [31:0] K3_Q16 = 32'sd72784620;
  localparam logic signed [31:0] K2_Q8  = 32'sd27148430;
  localparam logic [19:0]        K4_Q8  = 20'd748197;

  // Calibration mapping
  localparam logic signed [15:0] CAL_GAIN  = 16'sd2040;
  localparam logic signed [47:0] CAL_BIAS  = 48'sd1577582592;
  localparam logic signed [47:0] CAL_STEP  = 48'sd163840000;
  localparam logic signed [17:0] YAW_THR   = 18'sd6553;
  // ceil(2^30 / 5): exact floor(x / 5) for x below 2^30
  localparam logic [27:0]        CAL_RECIP = 28'd214748365;

  // Divider geometry: 63-bit magnitude dividend, 40-bit divisor
  localparam int unsigned DIV_NW = 63;
  localparam int unsigned DIV_DW = 40;

  typedef struct packed {
    logic signed [31:0] t1;
    logic signed [31:0] tr;
    logic signed [31:0] tp;
    logic               q1_neg;
    logic               q2_neg;
    logic [26:0]        cal_x;
    logic               cal_neg;
    logic               r0_zero;
    logic               links;
  } side_t;

endpackage

`default_nettype wire

>>> hw/rtl/pqsm_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Stand-alone; advances only when en_i is high.
`default_nettype none

module pqsm_div #(
  parameter int unsigned NW = 63,
  parameter int unsigned DW = 40
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[NW-1]};
      ge    = (trial >= {1'b0, den_in});
      if (ge) begin
        rem_d = DW'(trial - {1'b0, den_in});
      end else begin
        rem_d = trial[DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[NW-1];

endmodule

`default_nettype wire

>>> hw/rtl/pitch_quad_servo_mixer_unit.sv
// Pitch quad servo mixer: thrust and torques in, four servo pulse counts out.
// Uses pqsm_pkg and two pqsm_div instances.
//
// One item in, one item out; a new item is taken every cycle while the output
// side keeps up. From acceptance a result passes the two input stages (A, B), the
// two 63-stage bit-per-stage dividers (U3/U0 and (U1^2-U2^2)/U0) and the five
// output stages (E1 to E5). The whole pipeline holds while a result waits on
// m_axis_tready_i. Configuration writes are always taken and act on items at
// their last stages, so write only while no item is in flight.
`default_nettype none

module pitch_quad_servo_mixer_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // heave_thrust[31:0], roll_torque[63:32], pitch_torque[95:64],
  // yaw_torque[127:96], yaw_reference[145:128], zero fill
  input  wire logic [151:0] s_axis_tdata_i,
  // attitude_closed_loop[0], radio_link_open[1], telemetry_link_open[2]
  input  wire logic [2:0]   s_axis_tuser_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // servo_cmd_0[15:0], servo_cmd_1[31:16], servo_cmd_2[47:32], servo_cmd_3[63:48]
  output logic      [63:0]  m_axis_tdata_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i
);

  localparam int unsigned NW = pqsm_pkg::DIV_NW;
  localparam int unsigned DW = pqsm_pkg::DIV_DW;

  // Configuration registers
  logic [15:0] offset_q [4];
  logic [14:0] dlimit_q;
  logic        cal_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        offset_q[i] <= 16'd32768;
      end
      dlimit_q   <= 15'd8192;
      cal_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (pqsm_pkg::cfg_reg_e'(cfg_index_i))
        pqsm_pkg::REG_OFFSET0:  offset_q[0] <= cfg_data_i;
        pqsm_pkg::REG_OFFSET1:  offset_q[1] <= cfg_data_i;
        pqsm_pkg::REG_OFFSET2:  offset_q[2] <= cfg_data_i;
        pqsm_pkg::REG_OFFSET3:  offset_q[3] <= cfg_data_i;
        pqsm_pkg::REG_DLIMIT:   dlimit_q    <= cfg_data_i[14:0];
        pqsm_pkg::REG_CAL_MODE: cal_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless a result is held
  logic en;
  logic out_valid_q;
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_valid_q;

  // ---------------- Stage A: products ----------------
  logic signed [31:0] in_r0, in_r1, in_r2, in_r3;
  logic signed [17:0] in_yref;
  logic               in_closed;

  // open-loop attitude forces the torques to zero
  assign in_closed = s_axis_tuser_i[0];
  assign in_r0     = s_axis_tdata_i[31:0];
  assign in_r1     = in_closed ? s_axis_tdata_i[63:32] : 32'sd0;
  assign in_r2     = in_closed ? s_axis_tdata_i[95:64] : 32'sd0;
  assign in_r3     = in_closed ? s_axis_tdata_i[127:96] : 32'sd0;
  assign in_yref   = s_axis_tdata_i[145:128];

  logic               a_valid_q;
  logic signed [31:0] a_r0_q;
  logic signed [63:0] a_p1_q, a_pr_q, a_pp_q, a_p3_q, a_sq1_q, a_sq2_q;
  logic signed [47:0] a_cal_q;
  logic               a_kpos_q, a_kneg_q, a_links_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_r0_q    <= in_r0;
      a_p1_q    <= pqsm_pkg::K1_Q16 * in_r0;
      a_pr_q    <= pqsm_pkg::K3_Q16 * in_r1;
      a_pp_q    <= pqsm_pkg::K3_Q16 * in_r2;
      a_p3_q    <= pqsm_pkg::K2_Q8 * in_r3;
      a_sq1_q   <= in_r1 * in_r1;
      a_sq2_q   <= in_r2 * in_r2;
      a_cal_q   <= pqsm_pkg::CAL_GAIN * in_r0;
      a_kpos_q  <= (in_yref > pqsm_pkg::YAW_THR);
      a_kneg_q  <= (in_yref < -pqsm_pkg::YAW_THR);
      a_links_q <= s_axis_tuser_i[1] && s_axis_tuser_i[2];
    end
  end

  // ---------------- Stage B: operand prep ----------------
  function automatic logic signed [31:0] shr32_tz(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sh0000_0000_FFFF_FFFF : 64'sd0);
    return adj[63:32];
  endfunction

  logic signed [63:0] b_diff;
  logic signed [32:0] b_r0_ext;
  logic [31:0]        b_r0_abs;
  logic signed [47:0] b_cnum;
  logic [47:0]        b_cmag;
  pqsm_pkg::side_t    b_side_d;
  logic [NW-1:0]      b_num1_d, b_num2_d;
  logic [63:0]        b_neg1, b_neg2;

  always_comb begin
    b_diff   = a_sq1_q - a_sq2_q;
    b_r0_ext = {a_r0_q[31], a_r0_q};
    b_r0_abs = a_r0_q[31] ? 32'(-b_r0_ext) : a_r0_q;
    b_cnum   = a_cal_q - pqsm_pkg::CAL_BIAS;
    if (a_kpos_q) begin
      b_cnum = b_cnum + pqsm_pkg::CAL_STEP;
    end else if (a_kneg_q) begin
      b_cnum = b_cnum - pqsm_pkg::CAL_STEP;
    end
    b_cmag   = b_cnum[47] ? 48'(-b_cnum) : b_cnum;
    b_neg1   = 64'(-a_p3_q);
    b_neg2   = 64'(-b_diff);
    b_num1_d = a_p3_q[63] ? b_neg1[NW-1:0] : a_p3_q[NW-1:0];
    b_num2_d = b_diff[63] ? b_neg2[NW-1:0] : b_diff[NW-1:0];

    b_side_d.t1      = shr32_tz(a_p1_q);
    b_side_d.tr      = shr32_tz(a_pr_q);
    b_side_d.tp      = shr32_tz(a_pp_q);
    b_side_d.q1_neg  = a_p3_q[63] ^ a_r0_q[31];
    b_side_d.q2_neg  = b_diff[63] ^ a_r0_q[31];
    b_side_d.cal_x   = b_cmag[42:16];
    b_side_d.cal_neg = b_cnum[47];
    b_side_d.r0_zero = (a_r0_q == 32'sd0);
    b_side_d.links   = a_links_q;
  end

  logic            b_valid_q;
  pqsm_pkg::side_t b_side_q;
  logic [NW-1:0]   b_num1_q, b_num2_q;
  logic [DW-1:0]   b_den1_q, b_den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q <= b_side_d;
      b_num1_q <= b_num1_d;
      b_num2_q <= b_num2_d;
      b_den1_q <= {b_r0_abs, 8'd0};
      b_den2_q <= DW'(b_r0_abs);
    end
  end

  // ---------------- Dividers with matching sideband line ----------------
  logic [NW-1:0] quo1, quo2;

  pqsm_div #(.NW(NW), .DW(DW)) u_div_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (b_num1_q),
    .den_i (b_den1_q),
    .quo_o (quo1)
  );

  pqsm_div #(.NW(NW), .DW(DW)) u_div_quad (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (b_num2_q),
    .den_i (b_den2_q),
    .quo_o (quo2)
  );

  logic            dv_q [NW];
  pqsm_pkg::side_t ds_q [NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (en) begin
      dv_q[0] <= b_valid_q;
      for (int i = 1; i < NW; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_q[0] <= b_side_q;
      for (int i = 1; i < NW; i++) begin
        ds_q[i] <= ds_q[i-1];
      end
    end
  end

  // ---------------- Stage E1: quotient signs, T4 and calibration products ----
  logic               e1_valid_q;
  pqsm_pkg::side_t    e1_side_q;
  logic signed [63:0] e1_t2_q;
  logic [58:0]        e1_hp_q;
  logic [43:0]        e1_lp_q;
  logic [54:0]        e1_calp_q;
  logic [63:0]        e1_q1_ext;

  assign e1_q1_ext = {1'b0, quo1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
    end else if (en) begin
      e1_valid_q <= dv_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_side_q <= ds_q[NW-1];
      e1_t2_q   <= ds_q[NW-1].q1_neg ? $signed(-e1_q1_ext) : $signed(e1_q1_ext);
      e1_hp_q   <= 59'(quo2[62:24]) * 59'(pqsm_pkg::K4_Q8);
      e1_lp_q   <= 44'(quo2[23:0]) * 44'(pqsm_pkg::K4_Q8);
      e1_calp_q <= 55'(ds_q[NW-1].cal_x) * 55'(pqsm_pkg::CAL_RECIP);
    end
  end

  // ---------------- Stage E2: T4 assembled, calibration delta ----------------
  logic               e2_valid_q;
  pqsm_pkg::side_t    e2_side_q;
  logic signed [63:0] e2_t2_q, e2_t4_q, e2_cal_q;
  logic [63:0]        e2_t4mag, e2_calmag;

  assign e2_t4mag  = 64'(e1_hp_q) + 64'(e1_lp_q[43:24]);
  assign e2_calmag = 64'(e1_calp_q[54:30]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_valid_q <= 1'b0;
    end else if (en) begin
      e2_valid_q <= e1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_side_q <= e1_side_q;
      e2_t2_q   <= e1_t2_q;
      e2_t4_q   <= e1_side_q.q2_neg ? $signed(-e2_t4mag) : $signed(e2_t4mag);
      e2_cal_q  <= e1_side_q.cal_neg ? $signed(-e2_calmag) : $signed(e2_calmag);
    end
  end

  // ---------------- Stage E3: raw deltas and mode select ----------------
  logic signed [63:0] e3_g, e3_t1, e3_tr, e3_tp;
  logic signed [63:0] e3_d [4];

  always_comb begin
    e3_g  = e2_t2_q + e2_t4_q;
    e3_t1 = 64'(e2_side_q.t1);
    e3_tr = 64'(e2_side_q.tr);
    e3_tp = 64'(e2_side_q.tp);
    for (int i = 0; i < 4; i++) begin
      e3_d[i] = 64'sd0;
    end
    if (e2_side_q.links) begin
      if (cal_mode_q) begin
        for (int i = 0; i < 4; i++) begin
          e3_d[i] = e2_cal_q;
        end
      end else if (!e2_side_q.r0_zero) begin
        e3_d[0] = e3_tp - e3_t1 - e3_g;
        e3_d[1] = e3_t1 - e3_g - e3_tr;
        e3_d[2] = -(e3_t1 + e3_g + e3_tp);
        e3_d[3] = e3_t1 - e3_g + e3_tr;
      end
    end
  end

  logic               e3_valid_q;
  logic signed [63:0] e3_d_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3_valid_q <= 1'b0;
    end else if (en) begin
      e3_valid_q <= e2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        e3_d_q[i] <= e3_d[i];
      end
    end
  end

  // ---------------- Stage E4: clamp to the delta limit ----------------
  logic signed [63:0] lim;
  logic signed [15:0] e4_d [4];

  assign lim = 64'(dlimit_q);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (e3_d_q[i] > lim) begin
        e4_d[i] = 16'(lim);
      end else if (e3_d_q[i] < -lim) begin
        e4_d[i] = 16'(-lim);
      end else begin
        e4_d[i] = e3_d_q[i][15:0];
      end
    end
  end

  logic               e4_valid_q;
  logic signed [15:0] e4_d_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e4_valid_q <= 1'b0;
    end else if (en) begin
      e4_valid_q <= e3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        e4_d_q[i] <= e4_d[i];
      end
    end
  end

  // ---------------- Stage E5: offset add, saturate, output register --------
  logic signed [17:0] e5_sum [4];
  logic [15:0]        e5_cmd [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e5_sum[i] = $signed({2'b00, offset_q[i]}) + 18'(e4_d_q[i]);
      if (e5_sum[i] < 18'sd0) begin
        e5_cmd[i] = 16'd0;
      end else if (e5_sum[i] > 18'sd65535) begin
        e5_cmd[i] = 16'hFFFF;
      end else begin
        e5_cmd[i] = e5_sum[i][15:0];
      end
    end
  end

  logic [63:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= e4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {e5_cmd[3], e5_cmd[2], e5_cmd[1], e5_cmd[0]};
    end
  end

  assign m_axis_tdata_o = out_data_q;

endmodule

`default_nettype wire

>>> verif/pitch_quad_servo_mixer_unit_tb.sv
// Testbench for pitch_quad_servo_mixer_unit: random and directed control items,
// checked against an in-bench fixed-point mixing predictor. Depends on pqsm_pkg.
`timescale 1ns / 1ps

module pitch_quad_servo_mixer_unit_tb;

  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct {
    logic signed [31:0] thrust;
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic               closed;
    logic               radio;
    logic               telem;
    logic signed [17:0] yaw_ref;
  } ctrl_item_t;

  logic         clk_i;
  logic         rst_ni;
  logic [151:0] s_axis_tdata_i;
  logic [2:0]   s_axis_tuser_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [63:0]  m_axis_tdata_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;

  pitch_quad_servo_mixer_unit dut (.*);

  // bench copy of the registers
  logic [15:0] offs [4];
  logic [14:0] dlim;
  logic        cal_on;

  ctrl_item_t  pending_items[$];
  logic [63:0] expected_cmds[$];
  int unsigned sent_cnt, taken_cnt, result_cnt, err_cnt;
  int unsigned tx_gap, rx_wait, rx_hold;
  bit          tx_idle_on, rx_idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] mix_servos(ctrl_item_t it);
    longint r0, r1, r2, r3, yr, num, t1, tr, tp, t2, t4, q, hi, lo, lim, v;
    longint d [4];
    logic [63:0] res;
    r0 = it.thrust; r1 = it.roll; r2 = it.pitch; r3 = it.yaw; yr = it.yaw_ref;
    lim = dlim;
    for (int i = 0; i < 4; i++) d[i] = 0;
    if (!it.closed) begin
      r1 = 0; r2 = 0; r3 = 0;
    end
    if (it.radio && it.telem) begin
      if (cal_on) begin
        num = 2040 * r0 - 64'sd1577582592;
        if (yr > 6553) num += 64'sd163840000;
        else if (yr < -6553) num -= 64'sd163840000;
        for (int i = 0; i < 4; i++) d[i] = num / 64'sd327680;
      end else if (r0 != 0) begin
        t1 = (64'sd6914539 * r0) / 64'sd4294967296;
        tr = (64'sd72784620 * r1) / 64'sd4294967296;
        tp = (64'sd72784620 * r2) / 64'sd4294967296;
        t2 = (64'sd27148430 * r3) / (r0 * 256);
        q  = (r1 * r1 - r2 * r2) / r0;
        hi = q / 64'sd16777216;
        lo = q % 64'sd16777216;
        t4 = hi * 748197 + (lo * 748197) / 64'sd16777216;
        d[0] = -(t1 + t2 - tp + t4);
        d[1] = t1 - t2 - tr - t4;
        d[2] = -(t1 + t2 + tp + t4);
        d[3] = t1 - t2 + tr - t4;
      end
      for (int i = 0; i < 4; i++) begin
        if (d[i] > lim) d[i] = lim;
        else if (d[i] < -lim) d[i] = -lim;
      end
    end
    for (int i = 0; i < 4; i++) begin
      v = longint'(offs[i]) + d[i];
      if (v < 0) v = 0;
      else if (v > 65535) v = 65535;
      res[16*i +: 16] = v[15:0];
    end
    return res;
  endfunction

  function automatic logic signed [31:0] edge_val();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd1;
      3: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic ctrl_item_t rand_item();
    ctrl_item_t it;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // plausible flight values around hover thrust
      it.thrust = $urandom_range(0, 2000000);
      if ($urandom_range(0, 9) == 0) it.thrust = -it.thrust;
      it.roll  = int'($urandom_range(0, 262143)) - 131072;
      it.pitch = int'($urandom_range(0, 262143)) - 131072;
      it.yaw   = int'($urandom_range(0, 262143)) - 131072;
    end else if (kind <= 7) begin
      it.thrust = $urandom; it.roll = $urandom; it.pitch = $urandom; it.yaw = $urandom;
    end else begin
      it.thrust = (kind == 9) ? 32'sd0 : edge_val();
      it.roll = edge_val(); it.pitch = edge_val(); it.yaw = edge_val();
    end
    it.closed  = ($urandom_range(0, 7) != 0);
    it.radio   = ($urandom_range(0, 9) != 0);
    it.telem   = ($urandom_range(0, 9) != 0);
    it.yaw_ref = 18'(int'($urandom_range(0, 131072)) - 65536);
    return it;
  endfunction

  function automatic ctrl_item_t mk(logic signed [31:0] u0, logic signed [31:0] u1,
                                    logic signed [31:0] u2, logic signed [31:0] u3,
                                    logic [2:0] flags, logic signed [17:0] yref);
    ctrl_item_t it;
    it.thrust = u0; it.roll = u1; it.pitch = u2; it.yaw = u3;
    it.closed = flags[0]; it.radio = flags[1]; it.telem = flags[2];
    it.yaw_ref = yref;
    return it;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_cmds.size() != 0 || taken_cnt != sent_cnt)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // registers and scoreboard, sampled at the rising edge
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pqsm_pkg::REG_OFFSET0, pqsm_pkg::REG_OFFSET1,
          pqsm_pkg::REG_OFFSET2, pqsm_pkg::REG_OFFSET3: offs[cfg_index_i[1:0]] <= cfg_data_i;
          pqsm_pkg::REG_DLIMIT:   dlim   <= cfg_data_i[14:0];
          pqsm_pkg::REG_CAL_MODE: cal_on <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_cmds.push_back(mix_servos(mk(s_axis_tdata_i[31:0], s_axis_tdata_i[63:32],
          s_axis_tdata_i[95:64], s_axis_tdata_i[127:96], s_axis_tuser_i,
          s_axis_tdata_i[145:128])));
        taken_cnt++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        result_cnt++;
        rx_wait = rx_idle_on ? $urandom_range(0, 16) : 0;
        if (expected_cmds.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result %h", $time, m_axis_tdata_o);
        end else begin
          want = expected_cmds.pop_front();
          for (int i = 0; i < 4; i++)
            if (want[16*i +: 16] !== m_axis_tdata_o[16*i +: 16]) begin
              err_cnt++;
              $display("%0t: servo_cmd_%0d expected %0d got %0d", $time, i,
                       want[16*i +: 16], m_axis_tdata_o[16*i +: 16]);
            end
        end
      end
    end
  end

  // item driver
  always @(negedge clk_i) begin
    ctrl_item_t it;
    if (rst_ni) begin
      if (!(s_axis_tvalid_i && taken_cnt != sent_cnt)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          s_axis_tdata_i  <= {14'd0, it.yaw_ref, it.yaw, it.pitch, it.roll, it.thrust};
          s_axis_tuser_i  <= {it.telem, it.radio, it.closed};
          s_axis_tvalid_i <= 1'b1;
          sent_cnt++;
          tx_gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver; a long hold backs the pipeline up into the input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    s_axis_tdata_i = '0; s_axis_tuser_i = '0; s_axis_tvalid_i = 1'b0;
    m_axis_tready_i = 1'b0; cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    for (int i = 0; i < 4; i++) offs[i] = 16'd32768;
    dlim = 15'd8192; cal_on = 1'b0;
    sent_cnt = 0; taken_cnt = 0; result_cnt = 0; err_cnt = 0;
    tx_gap = 0; rx_wait = 0; rx_hold = 0; tx_idle_on = 1; rx_idle_on = 1;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: mixing corner cases
    pending_items.push_back(mk(32'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 3'b111, 18'sd0));
    pending_items.push_back(mk(32'sd773325, 32'sd6553, -32'sd6553, 32'sd3000, 3'b111, 18'sd0));
    pending_items.push_back(mk(32'sd773325, 32'sd6553, 32'sd6553, 32'sd3000, 3'b101, 18'sd0));
    pending_items.push_back(mk(32'sd773325, 32'sd6553, 32'sd6553, 32'sd3000, 3'b011, 18'sd0));
    pending_items.push_back(mk(32'sd773325, 32'sd9000, 32'sd700, 32'sd3000, 3'b110, 18'sd0));
    pending_items.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                               32'sh7fffffff, 3'b111, 18'sh1ffff));
    pending_items.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                               32'sh80000000, 3'b111, 18'sh20000));
    pending_items.push_back(mk(32'sd1, 32'sh7fffffff, 32'sd0, 32'sh7fffffff, 3'b111, 18'sd0));
    pending_items.push_back(mk(-32'sd1, 32'sd0, 32'sh7fffffff, 32'sh80000000, 3'b111, 18'sd0));
    pending_items.push_back(mk(32'sd655360, 32'sd0, 32'sd0, 32'sd0, 3'b000, 18'sd0));
    push_random(90);
    wait_idle();

    // extreme offsets, widest limit, no idling
    tx_idle_on = 0; rx_idle_on = 0;
    write_reg(pqsm_pkg::REG_OFFSET0, 16'd0);
    write_reg(pqsm_pkg::REG_OFFSET1, 16'hffff);
    write_reg(pqsm_pkg::REG_OFFSET2, 16'd0);
    write_reg(pqsm_pkg::REG_OFFSET3, 16'hffff);
    write_reg(pqsm_pkg::REG_DLIMIT, 16'hffff);
    push_random(100);
    wait_idle();

    // calibration mode around the yaw reference thresholds, zero limit first
    tx_idle_on = 1; rx_idle_on = 1;
    write_reg(pqsm_pkg::REG_CAL_MODE, 16'hffff);
    write_reg(pqsm_pkg::REG_DLIMIT, 16'd0);
    pending_items.push_back(mk(32'sd900000, 32'sd0, 32'sd0, 32'sd0, 3'b111, 18'sd0));
    wait_idle();
    write_reg(pqsm_pkg::REG_DLIMIT, 16'h7fff);
    for (int i = 0; i < 4; i++) write_reg(3'(pqsm_pkg::REG_OFFSET0 + i), 16'd32768);
    pending_items.push_back(mk(32'sd773325, 32'sd0, 32'sd0, 32'sd0, 3'b111, 18'sd6553));
    pending_items.push_back(mk(32'sd773325, 32'sd0, 32'sd0, 32'sd0, 3'b111, 18'sd6554));
    pending_items.push_back(mk(32'sd773325, 32'sd0, 32'sd0, 32'sd0, 3'b111, -18'sd6553));
    pending_items.push_back(mk(32'sd773325, 32'sd0, 32'sd0, 32'sd0, 3'b111, -18'sd6554));
    pending_items.push_back(mk(32'sh7fffffff, 32'sd0, 32'sd0, 32'sd0, 3'b111, 18'sd65536));
    pending_items.push_back(mk(32'sh80000000, 32'sd0, 32'sd0, 32'sd0, 3'b111, -18'sd65536));
    pending_items.push_back(mk(32'sd0, 32'sd0, 32'sd0, 32'sd0, 3'b011, 18'sd9000));
    push_random(90);
    wait_idle();

    // mixing with the receiver holding off long enough to fill the pipeline
    write_reg(pqsm_pkg::REG_CAL_MODE, 16'd0);
    write_reg(pqsm_pkg::REG_DLIMIT, 16'd3000);
    write_reg(REG_SPARE6, 16'd1234);
    write_reg(REG_SPARE7, 16'hffff);
    tx_idle_on = 0;
    rx_hold = 400;
    push_random(100);
    wait_idle();

    // random settings in both modes
    tx_idle_on = 1;
    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < 4; i++) write_reg(3'(pqsm_pkg::REG_OFFSET0 + i), 16'($urandom));
      write_reg(pqsm_pkg::REG_DLIMIT, 16'($urandom));
      write_reg(pqsm_pkg::REG_CAL_MODE, 16'(p));
      push_random(60);
      wait_idle();
    end

    $display("Covered %0d items over mixing and calibration settings,", taken_cnt);
    $display("%0d results checked with random idling and a long output stall.", result_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pqsm_pkg.sv
hw/rtl/pqsm_div.sv
hw/rtl/pitch_quad_servo_mixer_unit.sv
verif/pitch_quad_servo_mixer_unit_tb.sv
